@@ rtl/voice_allocator_note_to_regs_defines.svh @@
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VOICE_ALLOCATOR_NOTE_TO_REGS_DEFINES_SVH
`define VOICE_ALLOCATOR_NOTE_TO_REGS_DEFINES_SVH

// same-cycle implication
`define VATR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VATR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/vatr_pkg.sv @@
// ----------------------------------------------------------------------------
// vatr_pkg
// Types, constants and tables shared by the voice allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vatr_pkg;

	localparam int VOICES_DEF = 8;
	localparam int VIDX_W     = 4;   // voice index as carried in a register address

	localparam int PADDR_W = 3;
	localparam logic [0:0] REG_INSTRUMENT = 1'b0;
	localparam logic [3:0] INSTRUMENT_RST = 4'd3;

	localparam logic [5:0] ADDR_FNUM = 6'h10;
	localparam logic [5:0] ADDR_BLK  = 6'h20;
	localparam logic [5:0] ADDR_VOL  = 6'h30;
	localparam logic [7:0] KEYON_BIT = 8'h10;

	localparam logic [6:0]  KEY_OFFSET = 7'd12;
	localparam logic [12:0] RECIP_12   = 13'd43;  // k/12 == (k*43)>>9 for k < 128
	localparam logic [3:0]  OCT_MAX    = 4'd7;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_ON,
		EV_OFF
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t          kind;
		logic [VIDX_W-1:0] ch;
	} alloc_t;

	function automatic logic [8:0] fnum_lookup(input logic [3:0] idx);
		logic [8:0] f;
		unique case (idx)
			4'd0:    f = 9'd154;
			4'd1:    f = 9'd163;
			4'd2:    f = 9'd173;
			4'd3:    f = 9'd184;
			4'd4:    f = 9'd194;
			4'd5:    f = 9'd206;
			4'd6:    f = 9'd218;
			4'd7:    f = 9'd231;
			4'd8:    f = 9'd245;
			4'd9:    f = 9'd260;
			4'd10:   f = 9'd275;
			4'd11:   f = 9'd291;
			default: f = 9'd0;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

@@ rtl/vatr_note_decode.sv @@
// ----------------------------------------------------------------------------
// vatr_note_decode
// Folds the key down one octave (keys below 12 pass unchanged), splits it into
// note and octave, looks up the frequency number and forms the 4-bit block value.
// ----------------------------------------------------------------------------
`default_nettype none

module vatr_note_decode (
	input  wire logic [6:0] note_key,
	output logic      [6:0] key_fold,
	output logic      [8:0] fnum,
	output logic      [3:0] blk
);
	import vatr_pkg::*;

	logic [12:0] prod;
	logic [3:0]  quo;
	logic [3:0]  note;
	logic [2:0]  oct;

	always_comb begin
		key_fold = (note_key >= KEY_OFFSET) ? note_key - KEY_OFFSET : note_key;
		prod     = 13'(key_fold) * RECIP_12;
		quo      = prod[12:9];
		note     = 4'(key_fold - 7'(quo) * KEY_OFFSET);
		oct      = (quo > OCT_MAX) ? OCT_MAX[2:0] : quo[2:0];
		fnum     = fnum_lookup(note);
		blk      = {oct, fnum[8]};
	end

endmodule

`default_nettype wire

@@ rtl/vatr_voice_table.sv @@
// ----------------------------------------------------------------------------
// vatr_voice_table
// Per-voice key, age and on flag; picks the voice for an event and updates
// the table in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vatr_voice_table #(
	parameter int VOICES = vatr_pkg::VOICES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            go,
	input  wire logic            note_on,
	input  wire logic      [6:0] key_fold,
	output vatr_pkg::alloc_t     alloc
);
	import vatr_pkg::*;

	localparam int CH_W  = $clog2(VOICES);
	localparam int PRI_W = $clog2(VOICES);
	localparam logic [PRI_W-1:0] PRI_TOP = PRI_W'(VOICES - 1);

	logic [6:0]       key_q [VOICES];
	logic [PRI_W-1:0] pri_q [VOICES];
	logic [VOICES-1:0] on_q;

	logic            match_hit;
	logic [CH_W-1:0] match_idx;
	logic            free_hit;
	logic [CH_W-1:0] free_idx;
	logic [CH_W-1:0] ch;
	logic [PRI_W-1:0] own_pri;

	always_comb begin
		match_hit = 1'b0;
		match_idx = '0;
		free_hit  = 1'b0;
		free_idx  = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (key_q[i] == key_fold) begin
				match_hit = 1'b1;
				match_idx = CH_W'(i);
			end
			if (pri_q[i] == '0) begin
				free_hit = 1'b1;
				free_idx = CH_W'(i);
			end
		end
	end

	always_comb begin
		alloc.kind = EV_NONE;
		ch         = match_idx;
		own_pri    = pri_q[match_idx];
		if (go) begin
			if (note_on) begin
				alloc.kind = EV_ON;
				if (!match_hit)
					ch = free_hit ? free_idx : '0;
			end else if (match_hit && on_q[match_idx]) begin
				alloc.kind = EV_OFF;
			end
		end
		alloc.ch = VIDX_W'(ch);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				key_q[i] <= '0;
				pri_q[i] <= '0;
			end
			on_q <= '0;
		end else if (alloc.kind == EV_ON) begin
			for (int i = 0; i < VOICES; i++)
				if (CH_W'(i) == ch)
					pri_q[i] <= PRI_TOP;
				else if (pri_q[i] != '0)
					pri_q[i] <= pri_q[i] - 1'b1;
			on_q[ch]  <= 1'b1;
			key_q[ch] <= key_fold;
		end else if (alloc.kind == EV_OFF) begin
			for (int i = 0; i < VOICES; i++)
				if (CH_W'(i) == ch)
					pri_q[i] <= PRI_TOP;
				else if (pri_q[i] > own_pri)
					pri_q[i] <= pri_q[i] - 1'b1;
			on_q[ch]  <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/vatr_write_seq.sv @@
// ----------------------------------------------------------------------------
// vatr_write_seq
// Result register and word sequencer: one register write per cycle, four
// for a note-on, one for a note-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "voice_allocator_note_to_regs_defines.svh"

module vatr_write_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire vatr_pkg::alloc_t alloc,
	input  wire logic       [7:0] fnum_lo,
	input  wire logic       [3:0] blk,
	input  wire logic       [3:0] vel_hi,
	input  wire logic       [3:0] instrument,
	output logic                  strobe,
	output logic            [5:0] reg_addr,
	output logic            [7:0] reg_data,
	output logic                  last_write,
	output logic                  more
);
	import vatr_pkg::*;

	logic       strobe_q;
	logic       last_q;
	logic [1:0] left_q;
	logic [5:0] addr_q;
	logic [7:0] data_q;
	logic [5:0] ch_q;
	logic [7:0] vol_q;
	logic [7:0] fnum_q;
	logic [3:0] blk_q;
	logic [5:0] ch6;

	assign ch6 = 6'(alloc.ch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			left_q   <= '0;
		end else if (alloc.kind == EV_ON) begin
			strobe_q <= 1'b1;
			last_q   <= 1'b0;
			left_q   <= 2'd3;
		end else if (alloc.kind == EV_OFF) begin
			strobe_q <= 1'b1;
			last_q   <= 1'b1;
			left_q   <= '0;
		end else if (left_q != '0) begin
			strobe_q <= 1'b1;
			last_q   <= (left_q == 2'd1);
			left_q   <= left_q - 1'b1;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc.kind == EV_ON) begin
			addr_q <= ADDR_BLK + ch6;
			data_q <= '0;
			ch_q   <= ch6;
			vol_q  <= {instrument, ~vel_hi};
			fnum_q <= fnum_lo;
			blk_q  <= blk;
		end else if (alloc.kind == EV_OFF) begin
			addr_q <= ADDR_BLK + ch6;
			data_q <= 8'(blk);
		end else begin
			unique case (left_q)
				2'd3: begin
					addr_q <= ADDR_VOL + ch_q;
					data_q <= vol_q;
				end
				2'd2: begin
					addr_q <= ADDR_FNUM + ch_q;
					data_q <= fnum_q;
				end
				2'd1: begin
					addr_q <= ADDR_BLK + ch_q;
					data_q <= KEYON_BIT | 8'(blk_q);
				end
				default: ;
			endcase
		end
	end

	assign strobe     = strobe_q;
	assign reg_addr   = addr_q;
	assign reg_data   = data_q;
	assign last_write = last_q;
	assign more       = (left_q > 2'd1);

	`VATR_ASSERT_NOW(a_no_load_while_pending, alloc.kind != EV_NONE, left_q == '0, "event while words pending")
	`VATR_ASSERT_NOW(a_pending_has_word, left_q != '0, strobe_q, "pending words without a word out")
	`VATR_ASSERT_NOW(a_last_ends_event, strobe_q && last_q, left_q == '0, "last word with words left")
	`VATR_ASSERT_NEXT(a_on_four_words, alloc.kind == EV_ON, strobe_q && !last_q && left_q == 2'd3, "note-on sequence start")

endmodule

`default_nettype wire

@@ rtl/vatr_apb_regs.sv @@
// ----------------------------------------------------------------------------
// vatr_apb_regs
// APB register file: instrument number.
// ----------------------------------------------------------------------------
`default_nettype none

module vatr_apb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [vatr_pkg::PADDR_W-1:0] paddr,
	input  wire logic                  [31:0] pwdata,
	output logic                       [31:0] prdata,
	output logic                              pready,
	output logic                        [3:0] instrument
);
	import vatr_pkg::*;

	logic [3:0] instrument_q;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_INSTRUMENT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			instrument_q <= INSTRUMENT_RST;
		else if (psel && penable && pwrite && pready && reg_sel)
			instrument_q <= pwdata[3:0];
	end

	assign prdata     = reg_sel ? 32'(instrument_q) : '0;
	assign instrument = instrument_q;

endmodule

`default_nettype wire

@@ rtl/voice_allocator_note_to_regs.sv @@
// ----------------------------------------------------------------------------
// voice_allocator_note_to_regs
// Polyphonic voice allocator: note events in, sound chip register writes out.
// ----------------------------------------------------------------------------
// Use: drive note_key/velocity with start high; the event is taken at a
// clock edge where start is high and busy is low. velocity below 8 is a
// note-off.
// Results: each register write is on reg_addr/reg_data for one cycle with
// strobe high; last_write marks the final write of an event. The receiver
// cannot stall: every strobe cycle is a delivered word.
// Path: the first word passes the input register, then allocation into the
// result register.
// Words: a note-on gives four words, one per cycle; busy stays high until the
// final word is due, so the next event is taken as that word goes out. A
// note-off gives one word, an ignored note-off none; either frees the input once allocated.
// Reset: all voices cleared (key 0, age 0, off), instrument 3, outputs idle.
// Config: instrument at APB address 0; the user must see it written only while idle (unenforced).
// ----------------------------------------------------------------------------
`default_nettype none

module voice_allocator_note_to_regs #(
	parameter int VOICES = vatr_pkg::VOICES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                   [6:0] note_key,
	input  wire logic                   [6:0] velocity,
	output logic                              strobe,
	output logic                        [5:0] reg_addr,
	output logic                        [7:0] reg_data,
	output logic                              last_write,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [vatr_pkg::PADDR_W-1:0] paddr,
	input  wire logic                  [31:0] pwdata,
	output logic                       [31:0] prdata,
	output logic                              pready
);
	import vatr_pkg::*;

	logic       valid_s1;
	logic [6:0] key_s1;
	logic [6:0] vel_s1;

	logic [6:0] key_fold;
	logic [8:0] fnum;
	logic [3:0] blk;
	logic [3:0] instrument;
	logic       more;
	alloc_t     alloc;

	assign busy = valid_s1 || more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			key_s1 <= note_key;
			vel_s1 <= velocity;
		end
	end

	vatr_note_decode u_decode (
		.note_key (key_s1),
		.key_fold (key_fold),
		.fnum     (fnum),
		.blk      (blk)
	);

	vatr_voice_table #(
		.VOICES (VOICES)
	) u_voices (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (valid_s1),
		.note_on  (vel_s1[6:3] != 4'd0),
		.key_fold (key_fold),
		.alloc    (alloc)
	);

	vatr_write_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.alloc      (alloc),
		.fnum_lo    (fnum[7:0]),
		.blk        (blk),
		.vel_hi     (vel_s1[6:3]),
		.instrument (instrument),
		.strobe     (strobe),
		.reg_addr   (reg_addr),
		.reg_data   (reg_data),
		.last_write (last_write),
		.more       (more)
	);

	vatr_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.instrument (instrument)
	);

endmodule

`default_nettype wire
